### sv/frc_pkg.sv
// Shared types and constants for the fault report coalescer.
`default_nettype none
package frc_pkg;

  localparam int FAULT_DEPTH_DEF = 8;

  localparam logic [15:0] RESEND_GAP_RST = 16'd1000;
  localparam logic [15:0] BACKOFF_RST    = 16'd5000;
  localparam logic [3:0]  MAX_RETRY_RST  = 4'd3;

  // input item kinds
  localparam logic [2:0] KIND_STATUS  = 3'd0;
  localparam logic [2:0] KIND_FAULT   = 3'd1;
  localparam logic [2:0] KIND_TICK    = 3'd2;
  localparam logic [2:0] KIND_SEND    = 3'd3;
  localparam logic [2:0] KIND_CONNECT = 3'd4;

  // request codes, also used for the outstanding request
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_CONNECT = 2'd1;
  localparam logic [1:0] ACT_FAULT   = 2'd2;
  localparam logic [1:0] ACT_STATUS  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_RESEND_GAP = 2'd0;
  localparam logic [1:0] REG_BACKOFF    = 2'd1;
  localparam logic [1:0] REG_MAX_RETRY  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_HEAD_RD,
    ST_FINISH
  } frc_state_t;

  typedef struct packed {
    logic capture;
    logic apply;
    logic scan_clear;
    logic rd_scan;
    logic idx_inc;
    logic fault_insert;
    logic rd_head;
    logic finish;
  } frc_cmd_t;

  typedef struct packed {
    logic alarm_item;
    logic scan_end;
    logic match;
    logic out_free;
  } frc_status_t;

endpackage
`default_nettype wire

### sv/frc_ctrl.sv
// Sequencer for the fault report coalescer: one item at a time.
`default_nettype none
module frc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire frc_pkg::frc_status_t st,
  output frc_pkg::frc_cmd_t        cmd
);

  frc_pkg::frc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= frc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      frc_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid) state_next = frc_pkg::ST_APPLY;
      end
      frc_pkg::ST_APPLY: begin
        if (st.alarm_item) begin
          cmd.scan_clear = 1'b1;
          state_next     = frc_pkg::ST_SCAN_RD;
        end else begin
          cmd.apply  = 1'b1;
          state_next = frc_pkg::ST_HEAD_RD;
        end
      end
      frc_pkg::ST_SCAN_RD: begin
        if (st.scan_end) begin
          // no duplicate found: append or drop
          cmd.fault_insert = 1'b1;
          state_next       = frc_pkg::ST_HEAD_RD;
        end else begin
          cmd.rd_scan = 1'b1;
          state_next  = frc_pkg::ST_SCAN_CMP;
        end
      end
      frc_pkg::ST_SCAN_CMP: begin
        if (st.match) begin
          state_next = frc_pkg::ST_HEAD_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = frc_pkg::ST_SCAN_RD;
        end
      end
      frc_pkg::ST_HEAD_RD: begin
        cmd.rd_head = 1'b1;
        state_next  = frc_pkg::ST_FINISH;
      end
      frc_pkg::ST_FINISH: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = frc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = frc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### sv/frc_datapath.sv
// Link state, retry and wait registers, fault queue memory and result register.
`default_nettype none
module frc_datapath #(
  parameter int FAULT_DEPTH = frc_pkg::FAULT_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire frc_pkg::frc_cmd_t   cmd,
  output frc_pkg::frc_status_t     st,
  input  wire logic                cfg_wr,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_data,
  input  wire logic [2:0]          kind,
  input  wire logic [7:0]          alarm_code,
  input  wire logic [7:0]          head_id,
  input  wire logic                success,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               action,
  output logic [7:0]               out_alarm_code,
  output logic [7:0]               out_head_id,
  output logic                     link_up,
  output logic [3:0]               queued_faults,
  output logic                     fault_dropped,
  output logic                     pending
);

  localparam int PW = (FAULT_DEPTH > 1) ? $clog2(FAULT_DEPTH) : 1;
  localparam int CW = $clog2(FAULT_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(FAULT_DEPTH);
  localparam logic [SW-1:0] DEPTH_S = SW'(FAULT_DEPTH);
  localparam logic [PW-1:0] LAST_P  = PW'(FAULT_DEPTH - 1);

  // configuration
  logic [15:0] resend_gap;
  logic [15:0] backoff;
  logic [3:0]  max_retries;

  // captured item
  logic [2:0] kind_r;
  logic [7:0] code_r;
  logic [7:0] head_r;
  logic       ok_r;

  // protocol state
  logic        connected;
  logic        link_state;
  logic [3:0]  retry_count;
  logic [15:0] wait_remaining;
  logic        status_dirty;
  logic [1:0]  in_flight;
  logic        first_start;
  logic        dropped;

  // fault queue, circular
  logic [15:0]   mem [FAULT_DEPTH];
  logic [15:0]   rdata;
  logic [PW-1:0] head_ptr;
  logic [CW-1:0] count;
  logic [CW-1:0] scan_idx;

  logic [SW-1:0] scan_sum, tail_sum;
  logic [PW-1:0] scan_addr, tail_addr, rd_addr;
  logic [PW-1:0] head_inc;
  logic [3:0]    retry_inc;
  logic          pend;
  logic [1:0]    act;
  logic [CW+3:0] count_ext;

  assign scan_sum  = SW'(head_ptr) + SW'(scan_idx);
  assign tail_sum  = SW'(head_ptr) + SW'(count);
  assign scan_addr = (scan_sum >= DEPTH_S) ? PW'(scan_sum - DEPTH_S) : PW'(scan_sum);
  assign tail_addr = (tail_sum >= DEPTH_S) ? PW'(tail_sum - DEPTH_S) : PW'(tail_sum);
  assign head_inc  = (head_ptr == LAST_P) ? '0 : head_ptr + 1'b1;
  assign rd_addr   = cmd.rd_head ? head_ptr : scan_addr;
  assign retry_inc = retry_count + 4'd1;
  assign pend      = status_dirty || (count != '0);
  assign count_ext = {4'b0, count};

  always_comb begin
    st.alarm_item = (kind_r == frc_pkg::KIND_FAULT);
    st.scan_end   = (scan_idx == count);
    st.match      = (rdata == {head_r, code_r});
    st.out_free   = !out_valid || !out_stall;
  end

  always_comb begin
    act = frc_pkg::ACT_NONE;
    if (first_start && !connected) begin
      act = frc_pkg::ACT_CONNECT;
    end else if (pend && wait_remaining == '0) begin
      if (!connected)          act = frc_pkg::ACT_CONNECT;
      else if (count != '0)    act = frc_pkg::ACT_FAULT;
      else                     act = frc_pkg::ACT_STATUS;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fault_insert && count != DEPTH_C) mem[tail_addr] <= {head_r, code_r};
    if (cmd.rd_scan || cmd.rd_head) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= kind;
      code_r <= alarm_code;
      head_r <= head_id;
      ok_r   <= success;
    end
    if (cmd.scan_clear) scan_idx <= '0;
    else if (cmd.idx_inc) scan_idx <= scan_idx + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resend_gap  <= frc_pkg::RESEND_GAP_RST;
      backoff     <= frc_pkg::BACKOFF_RST;
      max_retries <= frc_pkg::MAX_RETRY_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        frc_pkg::REG_RESEND_GAP: resend_gap  <= cfg_data;
        frc_pkg::REG_BACKOFF:    backoff     <= cfg_data;
        frc_pkg::REG_MAX_RETRY:  max_retries <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      connected      <= 1'b0;
      link_state     <= 1'b0;
      retry_count    <= '0;
      wait_remaining <= '0;
      status_dirty   <= 1'b0;
      in_flight      <= frc_pkg::ACT_NONE;
      first_start    <= 1'b1;
      dropped        <= 1'b0;
      head_ptr       <= '0;
      count          <= '0;
    end else begin
      if (cmd.capture) dropped <= 1'b0;
      if (cmd.fault_insert) begin
        if (count == DEPTH_C) dropped <= 1'b1;
        else                  count   <= count + 1'b1;
      end
      if (cmd.apply) begin
        case (kind_r)
          frc_pkg::KIND_STATUS: status_dirty <= 1'b1;
          frc_pkg::KIND_TICK: begin
            if (wait_remaining != '0) wait_remaining <= wait_remaining - 16'd1;
          end
          frc_pkg::KIND_SEND: begin
            if (in_flight == frc_pkg::ACT_FAULT || in_flight == frc_pkg::ACT_STATUS) begin
              in_flight <= frc_pkg::ACT_NONE;
              if (ok_r) begin
                link_state  <= 1'b1;
                retry_count <= '0;
                if (in_flight == frc_pkg::ACT_FAULT) begin
                  if (count != '0) begin
                    head_ptr <= head_inc;
                    count    <= count - 1'b1;
                  end
                end else begin
                  status_dirty <= 1'b0;
                end
              end else if (retry_inc < max_retries) begin
                retry_count    <= retry_inc;
                wait_remaining <= resend_gap;
              end else begin
                // retries used up: drop the link and back off
                link_state     <= 1'b0;
                retry_count    <= '0;
                connected      <= 1'b0;
                wait_remaining <= backoff;
              end
            end
          end
          frc_pkg::KIND_CONNECT: begin
            if (in_flight == frc_pkg::ACT_CONNECT) begin
              if (ok_r) begin
                connected <= 1'b1;
                if (!first_start) status_dirty <= 1'b1;
              end else begin
                wait_remaining <= backoff;
              end
              first_start <= 1'b0;
              in_flight   <= frc_pkg::ACT_NONE;
            end
          end
          default: ;
        endcase
      end
      if (cmd.finish && in_flight == frc_pkg::ACT_NONE) in_flight <= act;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      action         <= (in_flight == frc_pkg::ACT_NONE) ? act : frc_pkg::ACT_NONE;
      out_alarm_code <= '0;
      out_head_id    <= '0;
      if (in_flight == frc_pkg::ACT_NONE && act == frc_pkg::ACT_FAULT) begin
        out_alarm_code <= rdata[7:0];
        out_head_id    <= rdata[15:8];
      end
      link_up       <= link_state;
      queued_faults <= count_ext[3:0];
      fault_dropped <= dropped;
      pending       <= pend;
    end
  end

endmodule
`default_nettype wire

### sv/fault_report_coalescer.sv
// Steps: the input is captured, then applied, or for a fault alarm the queued faults are
// compared in turn until a match (a read and a compare state per entry); the queue head is
// then read and the result is loaded into the output register once that is free. One item at a time;
// the next input is taken the cycle after the result is loaded into the output register.
// Reset (rst, synchronous): queue empty, link down, connect requested on the first item,
// registers back to gap 1000, backoff 5000, retries 3. Queue memory is not cleared.
`default_nettype none
module fault_report_coalescer #(
  parameter int FAULT_DEPTH = frc_pkg::FAULT_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  kind,
  input  wire logic [7:0]  alarm_code,
  input  wire logic [7:0]  head_id,
  input  wire logic        success,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       action,
  output logic [7:0]       out_alarm_code,
  output logic [7:0]       out_head_id,
  output logic             link_up,
  output logic [3:0]       queued_faults,
  output logic             fault_dropped,
  output logic             pending
);

  frc_pkg::frc_cmd_t    cmd;
  frc_pkg::frc_status_t st;

  assign cfg_ready = 1'b1;

  frc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  frc_datapath #(
    .FAULT_DEPTH (FAULT_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .cfg_wr         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .kind           (kind),
    .alarm_code     (alarm_code),
    .head_id        (head_id),
    .success        (success),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .action         (action),
    .out_alarm_code (out_alarm_code),
    .out_head_id    (out_head_id),
    .link_up        (link_up),
    .queued_faults  (queued_faults),
    .fault_dropped  (fault_dropped),
    .pending        (pending)
  );

endmodule
`default_nettype wire

### sv/frc_checker.sv
// Port-level checks for the fault report coalescer and their bind.
`default_nettype none
module frc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] action,
  input wire logic [7:0] out_alarm_code,
  input wire logic [7:0] out_head_id,
  input wire logic       pending
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(action) && $stable(out_alarm_code))
    else $error("stalled result changed");

  // one item at a time: no second transfer right after one
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  a_fault_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && action != frc_pkg::ACT_FAULT |-> out_alarm_code == '0 && out_head_id == '0)
    else $error("fault fields set without a fault report");

  // a report is only sent while something is pending
  a_report_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == frc_pkg::ACT_FAULT || action == frc_pkg::ACT_STATUS) |-> pending)
    else $error("report sent with nothing pending");

endmodule

bind fault_report_coalescer frc_checker u_frc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .action         (action),
  .out_alarm_code (out_alarm_code),
  .out_head_id    (out_head_id),
  .pending        (pending)
);
`default_nettype wire

### dv/fault_report_coalescer_tb.sv
// Self-checking testbench for fault_report_coalescer: directed table, then random phases.
module fault_report_coalescer_tb;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 32;     // worst item: a fault alarm scanning a full queue
  localparam int FAULT_DEPTH = frc_pkg::FAULT_DEPTH_DEF;
  localparam logic [2:0] KIND_RSVD_LO = 3'd5;
  localparam logic [2:0] KIND_RSVD_HI = 3'd7;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] code;
    logic [7:0] head;
    logic       link;
    logic [3:0] queued;
    logic       dropped;
    logic       pend;
  } decision_t;

  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
    logic [2:0]  kind;
    logic [7:0]  code;
    logic [7:0]  head;
    logic        ok;
    logic        typed_in;
    decision_t   want;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  kind;
  logic [7:0]  alarm_code;
  logic [7:0]  head_id;
  logic        success;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  action;
  logic [7:0]  out_alarm_code;
  logic [7:0]  out_head_id;
  logic        link_up;
  logic [3:0]  queued_faults;
  logic        fault_dropped;
  logic        pending;

  fault_report_coalescer DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .alarm_code(alarm_code),
    .head_id(head_id), .success(success),
    .out_valid(out_valid), .out_stall(out_stall), .action(action),
    .out_alarm_code(out_alarm_code), .out_head_id(out_head_id), .link_up(link_up),
    .queued_faults(queued_faults), .fault_dropped(fault_dropped), .pending(pending)
  );

  // predictor state
  logic [15:0] cfg_gap;
  logic [15:0] cfg_backoff;
  logic [3:0]  cfg_retry_limit;
  logic        session_open;
  logic        link_ok;
  logic [3:0]  fail_streak;
  logic [15:0] holdoff_ms;
  logic        status_stale;
  logic [15:0] fault_fifo [$];   // {head, code}
  logic [1:0]  outstanding;
  logic        at_startup;

  decision_t predicted_decisions [$];
  int        errors;
  int        cycles;
  int        accepted_items;
  logic      steady;
  logic      hold_off;

  function automatic decision_t dec(logic [1:0] a, logic [7:0] c, logic [7:0] h, logic l,
                                    logic [3:0] q, logic dr, logic p);
    decision_t d;
    d.action = a;
    d.code = c;
    d.head = h;
    d.link = l;
    d.queued = q;
    d.dropped = dr;
    d.pend = p;
    return d;
  endfunction

  function automatic plan_row_t ev(logic [2:0] k, logic [7:0] c, logic [7:0] h, logic ok);
    plan_row_t r;
    r = '0;
    r.kind = k;
    r.code = c;
    r.head = h;
    r.ok = ok;
    return r;
  endfunction

  function automatic plan_row_t ev_chk(logic [2:0] k, logic [7:0] c, logic [7:0] h, logic ok,
                                       decision_t want);
    plan_row_t r;
    r = ev(k, c, h, ok);
    r.typed_in = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic plan_row_t reg_wr(logic [1:0] idx, logic [15:0] val);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Absorbs one item into the predictor state and returns the decision it yields.
  function automatic decision_t next_decision(logic [2:0] k, logic [7:0] c, logic [7:0] h,
                                              logic ok);
    decision_t d;
    logic [15:0] entry;
    bit seen;
    d = '0;
    entry = {h, c};
    seen = 1'b0;
    case (k)
      frc_pkg::KIND_STATUS: status_stale = 1'b1;
      frc_pkg::KIND_FAULT: begin
        foreach (fault_fifo[i])
          if (fault_fifo[i] == entry) seen = 1'b1;
        // a duplicate is never flagged, even with the queue full
        if (!seen) begin
          if (fault_fifo.size() >= FAULT_DEPTH) d.dropped = 1'b1;
          else fault_fifo.push_back(entry);
        end
      end
      frc_pkg::KIND_TICK: if (holdoff_ms != 16'd0) holdoff_ms = holdoff_ms - 16'd1;
      frc_pkg::KIND_SEND:
        if (outstanding == frc_pkg::ACT_FAULT || outstanding == frc_pkg::ACT_STATUS) begin
          if (ok) begin
            link_ok = 1'b1;
            fail_streak = '0;
            if (outstanding == frc_pkg::ACT_FAULT) void'(fault_fifo.pop_front());
            else status_stale = 1'b0;
          end else begin
            fail_streak = fail_streak + 4'd1;
            if (fail_streak < cfg_retry_limit) begin
              holdoff_ms = cfg_gap;
            end else begin
              link_ok = 1'b0;
              fail_streak = '0;
              session_open = 1'b0;
              holdoff_ms = cfg_backoff;
            end
          end
          outstanding = frc_pkg::ACT_NONE;
        end
      frc_pkg::KIND_CONNECT: if (outstanding == frc_pkg::ACT_CONNECT) begin
        if (ok) begin
          session_open = 1'b1;
          if (!at_startup) status_stale = 1'b1;
        end else begin
          holdoff_ms = cfg_backoff;
        end
        at_startup = 1'b0;
        outstanding = frc_pkg::ACT_NONE;
      end
      default: ;
    endcase
    if (outstanding == frc_pkg::ACT_NONE) begin
      if (at_startup && !session_open) begin
        d.action = frc_pkg::ACT_CONNECT;
      end else if ((status_stale || fault_fifo.size() != 0) && holdoff_ms == 16'd0) begin
        if (!session_open) begin
          d.action = frc_pkg::ACT_CONNECT;
        end else if (fault_fifo.size() != 0) begin
          d.action = frc_pkg::ACT_FAULT;
          d.code = fault_fifo[0][7:0];
          d.head = fault_fifo[0][15:8];
        end else begin
          d.action = frc_pkg::ACT_STATUS;
        end
      end
      outstanding = d.action;
    end
    d.link = link_ok;
    d.queued = 4'(fault_fifo.size());
    d.pend = status_stale || fault_fifo.size() != 0;
    return d;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 100) $display("[cycle %0d] mismatch: %s", cycles, msg);
  endtask

  task automatic check_decision();
    decision_t got;
    decision_t want;
    got = dec(action, out_alarm_code, out_head_id, link_up, queued_faults, fault_dropped,
              pending);
    if (predicted_decisions.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected, action %0d", got.action));
    end else begin
      want = predicted_decisions.pop_front();
      if (got.action !== want.action)
        report_mismatch($sformatf("action %0d, want %0d", got.action, want.action));
      if (got.code !== want.code)
        report_mismatch($sformatf("out_alarm_code %0h, want %0h", got.code, want.code));
      if (got.head !== want.head)
        report_mismatch($sformatf("out_head_id %0h, want %0h", got.head, want.head));
      if (got.link !== want.link)
        report_mismatch($sformatf("link_up %0b, want %0b", got.link, want.link));
      if (got.queued !== want.queued)
        report_mismatch($sformatf("queued_faults %0d, want %0d", got.queued, want.queued));
      if (got.dropped !== want.dropped)
        report_mismatch($sformatf("fault_dropped %0b, want %0b", got.dropped, want.dropped));
      if (got.pend !== want.pend)
        report_mismatch($sformatf("pending %0b, want %0b", got.pend, want.pend));
    end
  endtask

  task automatic push_item(input logic [2:0] k, input logic [7:0] c, input logic [7:0] h,
                           input logic ok, input logic typed_in, input decision_t want);
    decision_t d;
    while (!steady && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    alarm_code <= c;
    head_id <= h;
    success <= ok;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    d = next_decision(k, c, h, ok);
    predicted_decisions.push_back(typed_in ? want : d);
    accepted_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (predicted_decisions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      frc_pkg::REG_RESEND_GAP: cfg_gap = val;
      frc_pkg::REG_BACKOFF:    cfg_backoff = val;
      frc_pkg::REG_MAX_RETRY:  cfg_retry_limit = val[3:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_directed();
    plan_row_t plan [$];
    plan = '{
      // first item asks for a connect even though status is the only thing pending
      ev_chk(frc_pkg::KIND_STATUS, 8'h00, 8'h00, 1'b0,
             dec(frc_pkg::ACT_CONNECT, 8'h00, 8'h00, 1'b0, 4'd0, 1'b0, 1'b1)),
      ev_chk(frc_pkg::KIND_FAULT, 8'hFF, 8'hFF, 1'b0,
             dec(frc_pkg::ACT_NONE, 8'h00, 8'h00, 1'b0, 4'd1, 1'b0, 1'b1)),
      // send outcome while a connect is outstanding: ignored
      ev_chk(frc_pkg::KIND_SEND, 8'h00, 8'h00, 1'b1,
             dec(frc_pkg::ACT_NONE, 8'h00, 8'h00, 1'b0, 4'd1, 1'b0, 1'b1)),
      // first connect does not re-mark status
      ev_chk(frc_pkg::KIND_CONNECT, 8'h00, 8'h00, 1'b1,
             dec(frc_pkg::ACT_FAULT, 8'hFF, 8'hFF, 1'b0, 4'd1, 1'b0, 1'b1)),
      ev_chk(frc_pkg::KIND_SEND, 8'h00, 8'h00, 1'b1,
             dec(frc_pkg::ACT_STATUS, 8'h00, 8'h00, 1'b1, 4'd0, 1'b0, 1'b1)),
      ev_chk(frc_pkg::KIND_SEND, 8'h00, 8'h00, 1'b1,
             dec(frc_pkg::ACT_NONE, 8'h00, 8'h00, 1'b1, 4'd0, 1'b0, 1'b0)),
      ev_chk(KIND_RSVD_HI, 8'hFF, 8'hFF, 1'b1,
             dec(frc_pkg::ACT_NONE, 8'h00, 8'h00, 1'b1, 4'd0, 1'b0, 1'b0)),
      ev_chk(frc_pkg::KIND_FAULT, 8'h00, 8'h00, 1'b0,
             dec(frc_pkg::ACT_FAULT, 8'h00, 8'h00, 1'b1, 4'd1, 1'b0, 1'b1)),
      ev_chk(frc_pkg::KIND_FAULT, 8'h00, 8'h00, 1'b0,
             dec(frc_pkg::ACT_NONE, 8'h00, 8'h00, 1'b1, 4'd1, 1'b0, 1'b1)),
      ev(frc_pkg::KIND_FAULT, 8'h01, 8'h80, 1'b0),
      ev(frc_pkg::KIND_FAULT, 8'h02, 8'h40, 1'b0),
      ev(frc_pkg::KIND_FAULT, 8'h04, 8'h20, 1'b0),
      ev(frc_pkg::KIND_FAULT, 8'h08, 8'h10, 1'b0),
      ev(frc_pkg::KIND_FAULT, 8'h10, 8'h08, 1'b0),
      ev(frc_pkg::KIND_FAULT, 8'h20, 8'h04, 1'b0),
      ev(frc_pkg::KIND_FAULT, 8'h40, 8'h02, 1'b0),
      ev_chk(frc_pkg::KIND_FAULT, 8'h80, 8'h01, 1'b0,
             dec(frc_pkg::ACT_NONE, 8'h00, 8'h00, 1'b1, 4'd8, 1'b1, 1'b1)),
      ev(frc_pkg::KIND_FAULT, 8'h40, 8'h02, 1'b0),
      ev(KIND_RSVD_LO, 8'h00, 8'h00, 1'b0),
      ev(frc_pkg::KIND_TICK, 8'h00, 8'h00, 1'b0),
      // zero gap and backoff, zero retry limit (upper data bits ignored)
      reg_wr(frc_pkg::REG_RESEND_GAP, 16'h0000),
      reg_wr(frc_pkg::REG_BACKOFF, 16'h0000),
      reg_wr(frc_pkg::REG_MAX_RETRY, 16'hFFF0),
      reg_wr(REG_UNUSED, 16'hFFFF),
      ev(frc_pkg::KIND_SEND, 8'h00, 8'h00, 1'b0),
      ev(frc_pkg::KIND_CONNECT, 8'h00, 8'h00, 1'b0),
      ev(frc_pkg::KIND_CONNECT, 8'h00, 8'h00, 1'b1),
      ev(frc_pkg::KIND_CONNECT, 8'h00, 8'h00, 1'b1),
      ev(frc_pkg::KIND_SEND, 8'h00, 8'h00, 1'b1),
      ev(frc_pkg::KIND_SEND, 8'h00, 8'h00, 1'b0),
      ev(frc_pkg::KIND_CONNECT, 8'h00, 8'h00, 1'b1)
    };
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        push_item(plan[i].kind, plan[i].code, plan[i].head, plan[i].ok, plan[i].typed_in,
                  plan[i].want);
      end
    end
  endtask

  // Mostly answers the outstanding request; the rest is events, faults, ticks and noise.
  task automatic run_random(input int target);
    int counted;
    int r;
    logic [2:0] k;
    logic [7:0] c;
    logic [7:0] h;
    logic ok;
    counted = 0;
    while (counted < target) begin
      r = $urandom_range(0, 99);
      c = 8'($urandom);
      h = 8'($urandom);
      ok = 1'($urandom);
      if (outstanding == frc_pkg::ACT_CONNECT && r < 70) begin
        k = frc_pkg::KIND_CONNECT;
        ok = ($urandom_range(0, 3) != 0);
      end else if ((outstanding == frc_pkg::ACT_FAULT || outstanding == frc_pkg::ACT_STATUS)
                   && r < 70) begin
        k = frc_pkg::KIND_SEND;
        ok = ($urandom_range(0, 2) != 0);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          k = frc_pkg::KIND_STATUS;
        end else if (r < 45) begin
          k = frc_pkg::KIND_FAULT;
          // small pool so that duplicates show up
          if ($urandom_range(0, 1) != 0) begin
            c = 8'($urandom_range(0, 3));
            h = 8'($urandom_range(0, 1));
          end
        end else if (r < 82) begin
          k = frc_pkg::KIND_TICK;
        end else if (r < 93) begin
          k = ($urandom_range(0, 1) != 0) ? frc_pkg::KIND_SEND : frc_pkg::KIND_CONNECT;
        end else begin
          k = 3'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI));
        end
      end
      push_item(k, c, h, ok, 1'b0, '0);
      counted++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // result side: check each transfer, then pick the next stall
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_stall === 1'b0) check_decision();
      out_stall <= hold_off || (!steady && $urandom_range(0, 99) < 13);
    end
  end

  // long hold-off on the result side so the block backs up into its input
  initial begin
    wait (accepted_items >= 200);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    logic [15:0] gap;
    logic [15:0] backoff;
    logic [3:0]  limit;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = '0;
    alarm_code = '0;
    head_id = '0;
    success = 1'b0;
    out_stall = 1'b0;
    steady = 1'b0;
    hold_off = 1'b0;
    errors = 0;
    accepted_items = 0;
    cfg_gap = frc_pkg::RESEND_GAP_RST;
    cfg_backoff = frc_pkg::BACKOFF_RST;
    cfg_retry_limit = frc_pkg::MAX_RETRY_RST;
    session_open = 1'b0;
    link_ok = 1'b0;
    fail_streak = '0;
    holdoff_ms = '0;
    status_stale = 1'b0;
    outstanding = frc_pkg::ACT_NONE;
    at_startup = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin gap = 16'd2; backoff = 16'd3; limit = 4'd2; end
        1: begin
          gap = 16'($urandom_range(0, 6));
          backoff = 16'($urandom_range(0, 6));
          limit = 4'($urandom_range(0, 15));
        end
        2: begin gap = 16'd1; backoff = 16'd1; limit = 4'd1; end
        3: begin
          gap = 16'($urandom_range(0, 4));
          backoff = 16'($urandom_range(2, 9));
          limit = 4'($urandom_range(1, 4));
        end
        4: begin gap = 16'd0; backoff = 16'd0; limit = 4'd15; end
        // largest waits last: once hit, they outlast the rest of the run
        default: begin gap = 16'hFFFF; backoff = 16'hFFFF; limit = 4'd15; end
      endcase
      drain();
      write_reg(frc_pkg::REG_RESEND_GAP, gap);
      write_reg(frc_pkg::REG_BACKOFF, backoff);
      write_reg(frc_pkg::REG_MAX_RETRY, {12'($urandom_range(0, 4095)), limit});
      if (p == 3) write_reg(REG_UNUSED, 16'($urandom));
      if (p == 2) steady <= 1'b1;
      run_random(p == 5 ? 30 : 120);
      if (p == 2) steady <= 1'b0;
    end

    drain();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
